>>> rtl/sssdf_pkg.sv
// ----------------------------------------------------------------------------
// sssdf_pkg
// Shared types, constants and the segment decode for the display framer.
// ----------------------------------------------------------------------------
package sssdf_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int FRAME_LEN   = DIGIT_COUNT + 3;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int SEG_IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam int NUM_LIMIT   = (10 ** DIGIT_COUNT) - 1;
  localparam int VAL_W       = ($clog2(NUM_LIMIT + 1) > 16) ? 16 : $clog2(NUM_LIMIT + 1);

  // divide by ten: exact for values below 2^22
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'hCCCCD;
  localparam int RECIP_SH    = 23;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_DISP_ON = 8'h88;
  localparam logic [7:0] COLON_BIT   = 8'h80;
  localparam logic [6:0] TIME_MAX    = 7'd99;

  typedef enum logic [1:0] {
    MODE_TIME   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef logic [DIGIT_COUNT-1:0][7:0] seg_arr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/sssdf_front.sv
// ----------------------------------------------------------------------------
// sssdf_front
// Request intake and decimal digit split, one digit per pipeline stage.
// ----------------------------------------------------------------------------
module sssdf_front import sssdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [6:0]  minutes,
  input  logic [6:0]  seconds,
  input  logic        colon,
  input  logic [15:0] number,
  input  logic        q_full,
  output logic        push,
  output seg_arr_t    push_data
);

  logic             stg_valid [0:DIGIT_COUNT];
  logic             stg_num   [0:DIGIT_COUNT];
  logic [VAL_W-1:0] stg_val   [0:DIGIT_COUNT];
  seg_arr_t         stg_segs  [0:DIGIT_COUNT];

  logic             advance;
  logic [VAL_W-1:0] quot [0:DIGIT_COUNT-1];
  logic [3:0]       rem  [0:DIGIT_COUNT-1];
  seg_arr_t         segs_next [0:DIGIT_COUNT-1];

  logic [6:0]       min_sat;
  logic [6:0]       sec_sat;
  logic [3:0]       tvals [0:3];
  seg_arr_t         time_segs;
  logic [VAL_W-1:0] num_sat;
  seg_arr_t         entry_segs;
  logic             entry_num;

  assign advance  = !(stg_valid[DIGIT_COUNT] && q_full);
  assign in_stall = !advance;
  assign push     = stg_valid[DIGIT_COUNT] && !q_full;
  assign push_data = stg_segs[DIGIT_COUNT];

  always_comb begin
    min_sat = (minutes > TIME_MAX) ? TIME_MAX : minutes;
    sec_sat = (seconds > TIME_MAX) ? TIME_MAX : seconds;
    // x * 205 >> 11 is exact for x below 1029
    tvals[0] = 4'((15'(min_sat) * 15'd205) >> 11);
    tvals[1] = 4'(min_sat - 7'(tvals[0]) * 7'd10);
    tvals[2] = 4'((15'(sec_sat) * 15'd205) >> 11);
    tvals[3] = 4'(sec_sat - 7'(tvals[2]) * 7'd10);
    time_segs = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (i < 4) begin
        time_segs[i] = seg_of(tvals[i % 4]);
      end
    end
    if (colon && DIGIT_COUNT >= 2) begin
      time_segs[1 % DIGIT_COUNT] = time_segs[1 % DIGIT_COUNT] | COLON_BIT;
    end

    if (32'(number) > 32'(NUM_LIMIT)) begin
      num_sat = VAL_W'(NUM_LIMIT);
    end else begin
      num_sat = VAL_W'(number);
    end

    case (mode)
      MODE_TIME: begin
        entry_segs = time_segs;
        entry_num  = 1'b0;
      end
      MODE_NUMBER: begin
        entry_segs = '0;
        entry_num  = 1'b1;
      end
      default: begin
        entry_segs = '0;
        entry_num  = 1'b0;
      end
    endcase
  end

  // one divide by ten per stage, from the registered value
  always_comb begin
    for (int s = 0; s < DIGIT_COUNT; s++) begin
      quot[s] = VAL_W'((($bits(stg_val[s]) + RECIP_W)'(stg_val[s]) * RECIP) >> RECIP_SH);
      rem[s]  = 4'(stg_val[s] - VAL_W'(quot[s] * 4'd10));
      segs_next[s] = stg_segs[s];
      // rightmost digit first
      if (stg_num[s]) begin
        segs_next[s][DIGIT_COUNT-1-s] = seg_of(rem[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIGIT_COUNT; s++) begin
        stg_valid[s] <= 1'b0;
      end
    end else if (advance) begin
      stg_valid[0] <= in_valid;
      for (int s = 1; s <= DIGIT_COUNT; s++) begin
        stg_valid[s] <= stg_valid[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_num[0]  <= entry_num;
      stg_val[0]  <= num_sat;
      stg_segs[0] <= entry_segs;
      for (int s = 1; s <= DIGIT_COUNT; s++) begin
        stg_num[s]  <= stg_num[s-1];
        stg_val[s]  <= quot[s-1];
        stg_segs[s] <= segs_next[s-1];
      end
    end
  end

endmodule

>>> rtl/sssdf_fifo.sv
// ----------------------------------------------------------------------------
// sssdf_fifo
// Short queue of digit pattern sets between the front and the back.
// ----------------------------------------------------------------------------
module sssdf_fifo import sssdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  seg_arr_t     push_data,
  input  logic         pop,
  output seg_arr_t     pop_data,
  output fifo_status_t status
);

  seg_arr_t              entries [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/sssdf_back.sv
// ----------------------------------------------------------------------------
// sssdf_back
// Byte sequencer: frames one queued request into the command stream.
// ----------------------------------------------------------------------------
module sssdf_back import sssdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fifo_status_t q_status,
  input  seg_arr_t     q_data,
  output logic         pop,
  input  logic [2:0]   brightness,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   bus_byte,
  output logic         start_before,
  output logic         stop_after,
  output logic         last
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             final_byte;
  logic [7:0]       byte_next;
  logic             start_next;
  logic             stop_next;

  assign load       = !q_status.empty && (!out_valid || !out_stall);
  assign final_byte = (idx == IDX_W'(FRAME_LEN - 1));
  assign pop        = load && final_byte;

  always_comb begin
    if (idx == IDX_W'(0)) begin
      byte_next  = CMD_DATA;
      start_next = 1'b1;
      stop_next  = 1'b1;
    end else if (idx == IDX_W'(1)) begin
      byte_next  = CMD_ADDR;
      start_next = 1'b1;
      stop_next  = 1'b0;
    end else if (final_byte) begin
      byte_next  = CMD_DISP_ON | {5'b0, brightness};
      start_next = 1'b1;
      stop_next  = 1'b1;
    end else begin
      byte_next  = q_data[SEG_IDX_W'(idx - IDX_W'(2))];
      start_next = 1'b0;
      stop_next  = (idx == IDX_W'(FRAME_LEN - 2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_byte ? '0 : idx + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bus_byte     <= byte_next;
      start_before <= start_next;
      stop_after   <= stop_next;
      last         <= final_byte;
    end
  end

endmodule

>>> rtl/seven_segment_serial_display_framer_core.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_framer_core
// Four-digit seven-segment display request framer, top level.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one request: time, number or
// clear. Output channel (out_valid / out_stall) gives the framed command
// stream, one byte per transfer, DIGIT_COUNT + 3 bytes per request, with
// start/stop flags and last on the display-on byte.
// wr_en / wr_data write the brightness level; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Path of a request: one divide-by-ten stage per digit behind the intake
// register, then the queue write, then the output register.
// The output sequencer emits one byte per cycle while the queue holds a
// request and out_stall is low; the intake takes a new request every cycle
// while the queue has room.
// Reset: brightness returns to 7, pipeline and queue empty, no output valid.
// A stalled receiver holds the output byte; the queue then fills and the
// intake raises in_stall until space frees up.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_framer_core import sssdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [6:0]  minutes,
  input  logic [6:0]  seconds,
  input  logic        colon,
  input  logic [15:0] number,
  input  logic        wr_en,
  input  logic [2:0]  wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  bus_byte,
  output logic        start_before,
  output logic        stop_after,
  output logic        last
);

  logic [2:0]   brightness;
  logic         push;
  seg_arr_t     push_data;
  logic         pop;
  seg_arr_t     pop_data;
  fifo_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
    end else if (wr_en) begin
      brightness <= wr_data;
    end
  end

  sssdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .minutes   (minutes),
    .seconds   (seconds),
    .colon     (colon),
    .number    (number),
    .q_full    (q_status.full),
    .push      (push),
    .push_data (push_data)
  );

  sssdf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  sssdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_data       (pop_data),
    .pop          (pop),
    .brightness   (brightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_byte     (bus_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_status.empty)
    else $error("queue reports full and empty together");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_status.full)
    else $error("intake stalled while the queue has room");

  a_last_is_disp_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (start_before && stop_after && bus_byte[7:3] == 5'b10001))
    else $error("final byte is not a framed display-on command");

  a_pop_on_final: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && last))
    else $error("queue entry released before its final byte");
`endif

endmodule

>>> tb/sv/seven_segment_serial_display_framer_core_test.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_framer_core_test
// A table of directed requests runs first, then randomised time, number,
// clear and spare requests under several brightness levels. Every bus byte
// is checked against a local model of the seven-byte command frame, with
// random gaps on the request side and random back-pressure on the bus side.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sssdf_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, shows a blank display
  localparam int IDLE_MAX       = 12;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE         = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 58;
  localparam int NUM_ROWS       = 21;

  // digit 9 in the top byte down to digit 0 in the bottom byte
  localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                    8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
  localparam logic [11:0] FIXED_LEVELS = {3'b010, 3'b101, 3'd7, 3'd0};

  // leftmost digit in the top byte
  typedef logic [8*DIGIT_COUNT-1:0] digit_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start_b;
    logic       stop_a;
    logic       last_b;
  } bus_xfer_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  mins;
    logic [6:0]  secs;
    logic        col;
    logic [15:0] num;
    logic        known;
    digit_word_t segs;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = 2'd0;
  logic [6:0]  minutes = 7'd0;
  logic [6:0]  seconds = 7'd0;
  logic        colon = 1'b0;
  logic [15:0] number = 16'd0;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_data = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  bus_byte;
  logic        start_before;
  logic        stop_after;
  logic        last;

  bus_xfer_t   expected_bytes[$];
  logic [2:0]  brightness = 3'd7;
  int          gap_max = IDLE_MAX;
  int          hold_max = IDLE_MAX;
  logic        long_hold = 1'b0;
  int          requests_sent = 0;
  int          bytes_checked = 0;
  int          levels_used = 1;
  int          mismatches = 0;
  int          idle_cycles = 0;

  request_row_t rows [NUM_ROWS] = '{
    '{MODE_CLEAR,  7'd0,   7'd0,   1'b0, 16'd0,     1'b1, 32'h00000000},
    '{MODE_SPARE,  7'd127, 7'd127, 1'b1, 16'hFFFF,  1'b1, 32'h00000000},
    '{MODE_CLEAR,  7'd12,  7'd34,  1'b1, 16'd1234,  1'b1, 32'h00000000},
    '{MODE_TIME,   7'd0,   7'd0,   1'b0, 16'd0,     1'b1, 32'h3F3F3F3F},
    '{MODE_TIME,   7'd99,  7'd99,  1'b1, 16'd0,     1'b1, 32'h6FEF6F6F},
    '{MODE_TIME,   7'd127, 7'd127, 1'b0, 16'hFFFF,  1'b1, 32'h6F6F6F6F},
    '{MODE_TIME,   7'd100, 7'd0,   1'b1, 16'd0,     1'b1, 32'h6FEF3F3F},
    '{MODE_TIME,   7'd0,   7'd100, 1'b0, 16'd0,     1'b1, 32'h3F3F6F6F},
    '{MODE_TIME,   7'd12,  7'd34,  1'b1, 16'd0,     1'b0, 32'h00000000},
    '{MODE_TIME,   7'd56,  7'd78,  1'b0, 16'd0,     1'b0, 32'h00000000},
    '{MODE_TIME,   7'd85,  7'd42,  1'b1, 16'd9,     1'b0, 32'h00000000},
    '{MODE_TIME,   7'd9,   7'd10,  1'b1, 16'd0,     1'b0, 32'h00000000},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd0,     1'b1, 32'h3F3F3F3F},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd9999,  1'b1, 32'h6F6F6F6F},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd10000, 1'b1, 32'h6F6F6F6F},
    '{MODE_NUMBER, 7'd127, 7'd127, 1'b1, 16'hFFFF,  1'b1, 32'h6F6F6F6F},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'h8000,  1'b1, 32'h6F6F6F6F},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b1, 16'd1234,  1'b0, 32'h00000000},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd5678,  1'b0, 32'h00000000},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd9,     1'b0, 32'h00000000},
    '{MODE_NUMBER, 7'd0,   7'd0,   1'b0, 16'd8080,  1'b0, 32'h00000000}
  };

  seven_segment_serial_display_framer_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .minutes      (minutes),
    .seconds      (seconds),
    .colon        (colon),
    .number       (number),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_byte     (bus_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic digit_word_t display_digits(logic [1:0] m, logic [6:0] mi,
                                                 logic [6:0] se, logic c,
                                                 logic [15:0] nu);
    digit_word_t w;
    int          mm, ss, v, i;
    w  = '0;
    mm = (mi > 99) ? 99 : mi;
    ss = (se > 99) ? 99 : se;
    v  = (nu > 10 ** DIGIT_COUNT - 1) ? 10 ** DIGIT_COUNT - 1 : nu;
    if (m == MODE_TIME) begin
      w = {GLYPHS[8*(mm/10) +: 8], GLYPHS[8*(mm%10) +: 8],
           GLYPHS[8*(ss/10) +: 8], GLYPHS[8*(ss%10) +: 8]};
      // colon rides on bit 7 of digit one
      if (c) w[8*(DIGIT_COUNT-2) + 7] = 1'b1;
    end else if (m == MODE_NUMBER) begin
      for (i = DIGIT_COUNT - 1; i >= 0; i--) begin
        w[8*(DIGIT_COUNT-1-i) +: 8] = GLYPHS[8*(v%10) +: 8];
        v = v / 10;
      end
    end
    return w;
  endfunction

  task automatic queue_frame(digit_word_t w);
    int i;
    expected_bytes.push_back(bus_xfer_t'{CMD_DATA, 1'b1, 1'b1, 1'b0});
    expected_bytes.push_back(bus_xfer_t'{CMD_ADDR, 1'b1, 1'b0, 1'b0});
    for (i = 0; i < DIGIT_COUNT; i++) begin
      expected_bytes.push_back(bus_xfer_t'{w[8*(DIGIT_COUNT-1-i) +: 8], 1'b0,
                                           logic'(i == DIGIT_COUNT - 1), 1'b0});
    end
    expected_bytes.push_back(bus_xfer_t'{CMD_DISP_ON | {5'd0, brightness},
                                         1'b1, 1'b1, 1'b1});
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic offer(logic [1:0] m, logic [6:0] mi, logic [6:0] se, logic c,
                       logic [15:0] nu, logic known, digit_word_t typed);
    int   gap;
    logic took;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    minutes  <= mi;
    seconds  <= se;
    colon    <= c;
    number   <= nu;
    do begin
      @(negedge clk);
      took = (in_stall === 1'b0);
      @(posedge clk);
    end while (!took);
    queue_frame(known ? typed : display_digits(m, mi, se, c, nu));
    requests_sent++;
  endtask

  task automatic random_request;
    int          pick;
    logic [1:0]  m;
    logic [6:0]  mi, se;
    logic [15:0] nu;
    pick = $urandom_range(0, 99);
    if (pick < 45) m = MODE_TIME;
    else if (pick < 85) m = MODE_NUMBER;
    else if (pick < 95) m = MODE_CLEAR;
    else m = MODE_SPARE;
    mi = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                     : 7'($urandom_range(0, 99));
    se = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                     : 7'($urandom_range(0, 99));
    nu = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 9999));
    offer(m, mi, se, 1'($urandom_range(0, 1)), nu, 1'b0, '0);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_brightness(logic [2:0] level);
    wr_en   <= 1'b1;
    wr_data <= level;
    @(posedge clk);
    wr_en <= 1'b0;
    brightness = level;
    levels_used++;
  endtask

  task automatic check_byte(bus_xfer_t got);
    bus_xfer_t want;
    bytes_checked++;
    if (expected_bytes.size() == 0) begin
      $error("bus byte %02h arrived with nothing outstanding", got.data);
      mismatches++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.data !== want.data) begin
      $error("bus_byte: expected %02h, got %02h", want.data, got.data);
      mismatches++;
    end
    if (got.start_b !== want.start_b) begin
      $error("start_before: expected %0b, got %0b", want.start_b, got.start_b);
      mismatches++;
    end
    if (got.stop_a !== want.stop_a) begin
      $error("stop_after: expected %0b, got %0b", want.stop_a, got.stop_a);
      mismatches++;
    end
    if (got.last_b !== want.last_b) begin
      $error("last: expected %0b, got %0b", want.last_b, got.last_b);
      mismatches++;
    end
  endtask

  // bus side: random hold before each transfer, one long hold on request
  initial begin
    int hold;
    forever begin
      hold = long_hold ? LONG_HOLD : $urandom_range(0, hold_max);
      long_hold = 1'b0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      check_byte(bus_xfer_t'{bus_byte, start_before, stop_after, last});
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int i, p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < NUM_ROWS; i++) begin
      offer(rows[i].mode, rows[i].mins, rows[i].secs, rows[i].col, rows[i].num,
            rows[i].known, rows[i].segs);
    end
    for (p = 0; p < PHASES; p++) begin
      drain();
      set_brightness((p < 4) ? FIXED_LEVELS[3*p +: 3] : 3'($urandom_range(0, 7)));
      gap_max  = (p == 1) ? 0 : IDLE_MAX;
      hold_max = (p == 1 || p == 4) ? 0 : IDLE_MAX;
      // keep offering while the bus side sits on a long stall
      if (p == 2) begin
        gap_max   = 1;
        long_hold = 1'b1;
      end
      repeat (PHASE_ITEMS) random_request();
    end
    drain();
    $display("%0d requests, %0d bus bytes checked, %0d brightness levels",
             requests_sent, bytes_checked, levels_used);
    $display("time, number, clear and spare-mode requests incl. saturation and colon");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sssdf_pkg.sv
rtl/sssdf_front.sv
rtl/sssdf_fifo.sv
rtl/sssdf_back.sv
rtl/seven_segment_serial_display_framer_core.sv
tb/sv/seven_segment_serial_display_framer_core_test.sv
